// ===== rtl/pca_pkg.sv =====
// Shared types and constants for the pixel covariance accumulator.
package pca_pkg;

    localparam int SumW = 48;
    localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
    localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_ALL     = 2'd0,
        MODE_HITS    = 2'd1,
        MODE_HIT_COV = 2'd2,
        MODE_SIG     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_SCALE   = 2'd0,
        REG_SUBMAP  = 2'd1,
        REG_WEIGHTS = 2'd2,
        REG_MODE    = 2'd3
    } reg_idx_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted item and compute its address
        logic clr_step;  // write zeros at the clear address
        logic read;      // issue the memory reads for the item's pixel
        logic compute;   // apply the scale multiply and rounding to the products
        logic write;     // write back and load the result register
    } pca_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // clear sweep at its final entry
    } pca_stat_t;

    // Saturating 48-bit add of two signed values
    function automatic logic signed [SumW-1:0] sat_add(
        input logic signed [SumW-1:0] a,
        input logic signed [SumW-1:0] b
    );
        logic signed [SumW:0] s;
        s = {a[SumW-1], a} + {b[SumW-1], b};
        if (s[SumW] != s[SumW-1])
            return s[SumW] ? SumMin : SumMax;
        return s[SumW-1:0];
    endfunction

endpackage

// ===== rtl/pixel_covariance_accumulator_top.sv =====
// Top level of the pixel covariance accumulator.
//
// channel | signals                          | direction
// input   | in_valid, in_ready, sample fields | in
// result  | out_valid, out_ready, result fields| out
// config  | cfg_we, cfg_index, cfg_data       | in
//
// Each item steps through capture and address, memory read with the weight
// products, scale multiply, then write-back and result load; the pixel memory
// read-modify-write sets this order. After reset a clear pass writes zeros over
// all MAP_PIXELS entries, one per cycle, before the first item is taken.
// A stalled result holds the block in its write step until it is taken.
module pixel_covariance_accumulator_top import pca_pkg::*; #(
    parameter int MAP_PIXELS  = 4096,
    parameter int MAX_WEIGHTS = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [12:0]     submap_index,
    input  logic signed [12:0]     pixel_index,
    input  logic signed [15:0]     weight_first,
    input  logic signed [15:0]     weight_second,
    input  logic signed [15:0]     weight_third,
    input  logic signed [23:0]     sample_value,
    input  logic                   last_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [31:0]            hit_total,
    output logic signed [47:0]     zsum_first,
    output logic signed [47:0]     zsum_second,
    output logic signed [47:0]     zsum_third,
    output logic signed [47:0]     cov_aa,
    output logic signed [47:0]     cov_ab,
    output logic signed [47:0]     cov_ac,
    output logic signed [47:0]     cov_bb,
    output logic signed [47:0]     cov_bc,
    output logic signed [47:0]     cov_cc,
    output logic                   batch_done
);

    logic [15:0] scale_reg;
    logic [12:0] submap_reg;
    logic [1:0]  weights_reg;
    logic [1:0]  mode_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= 16'd256;
            submap_reg  <= 13'd4096;
            weights_reg <= 2'd3;
            mode_reg    <= MODE_ALL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE:   scale_reg   <= cfg_data;
                REG_SUBMAP:  submap_reg  <= cfg_data[12:0];
                REG_WEIGHTS: weights_reg <= cfg_data[1:0];
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    pca_cmd_t  cmd;
    pca_stat_t stat;

    pca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pca_datapath #(
        .MAP_PIXELS  (MAP_PIXELS),
        .MAX_WEIGHTS (MAX_WEIGHTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_scale     (scale_reg),
        .cfg_submap    (submap_reg),
        .cfg_weights   (weights_reg),
        .cfg_mode      (mode_reg),
        .submap_index  (submap_index),
        .pixel_index   (pixel_index),
        .weight_first  (weight_first),
        .weight_second (weight_second),
        .weight_third  (weight_third),
        .sample_value  (sample_value),
        .last_sample   (last_sample),
        .status        (status),
        .hit_total     (hit_total),
        .zsum_first    (zsum_first),
        .zsum_second   (zsum_second),
        .zsum_third    (zsum_third),
        .cov_aa        (cov_aa),
        .cov_ab        (cov_ab),
        .cov_ac        (cov_ac),
        .cov_bb        (cov_bb),
        .cov_bc        (cov_bc),
        .cov_cc        (cov_cc),
        .batch_done    (batch_done)
    );

endmodule

// ===== rtl/pca_datapath.sv =====
// Datapath: address, products, memories, saturating sums and result register.
module pca_datapath import pca_pkg::*; #(
    parameter int MAP_PIXELS  = 4096,
    parameter int MAX_WEIGHTS = 3,
    localparam int AW = (MAP_PIXELS > 1) ? $clog2(MAP_PIXELS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pca_cmd_t                 cmd,
    output pca_stat_t                stat,
    input  logic [15:0]              cfg_scale,
    input  logic [12:0]              cfg_submap,
    input  logic [1:0]               cfg_weights,
    input  logic [1:0]               cfg_mode,
    input  logic signed [12:0]       submap_index,
    input  logic signed [12:0]       pixel_index,
    input  logic signed [15:0]       weight_first,
    input  logic signed [15:0]       weight_second,
    input  logic signed [15:0]       weight_third,
    input  logic signed [23:0]       sample_value,
    input  logic                     last_sample,
    output logic [1:0]               status,
    output logic [31:0]              hit_total,
    output logic signed [SumW-1:0]   zsum_first,
    output logic signed [SumW-1:0]   zsum_second,
    output logic signed [SumW-1:0]   zsum_third,
    output logic signed [SumW-1:0]   cov_aa,
    output logic signed [SumW-1:0]   cov_ab,
    output logic signed [SumW-1:0]   cov_ac,
    output logic signed [SumW-1:0]   cov_bb,
    output logic signed [SumW-1:0]   cov_bc,
    output logic signed [SumW-1:0]   cov_cc,
    output logic                     batch_done
);

    // Memories: one word per pixel, lanes for each weight and each covariance slot
    logic [31:0]            hit_mem [MAP_PIXELS];
    logic signed [SumW-1:0] sig_mem0 [MAP_PIXELS];
    logic signed [SumW-1:0] sig_mem1 [MAP_PIXELS];
    logic signed [SumW-1:0] sig_mem2 [MAP_PIXELS];
    logic signed [SumW-1:0] cov_mem0 [MAP_PIXELS];
    logic signed [SumW-1:0] cov_mem1 [MAP_PIXELS];
    logic signed [SumW-1:0] cov_mem2 [MAP_PIXELS];
    logic signed [SumW-1:0] cov_mem3 [MAP_PIXELS];
    logic signed [SumW-1:0] cov_mem4 [MAP_PIXELS];
    logic signed [SumW-1:0] cov_mem5 [MAP_PIXELS];

    // Captured item
    logic signed [15:0] w0_reg, w1_reg, w2_reg;
    logic signed [23:0] sig_reg;
    logic               last_reg;
    logic [1:0]         st_reg;
    logic [AW-1:0]      addr_reg;
    logic [1:0]         n_reg;
    logic [1:0]         mode_reg;
    logic [15:0]        scale_reg;
    logic [AW-1:0]      clr_reg;

    // Address: submap * size + pixel, range checked at full width
    logic [25:0] lin_addr;
    logic [1:0]  n_eff;
    assign lin_addr = 26'(submap_index[11:0]) * 26'(cfg_submap) + 26'(pixel_index[11:0]);
    always_comb
    begin
        if (cfg_weights == 2'd0)
            n_eff = 2'd1;
        else if (32'(cfg_weights) > MAX_WEIGHTS)
            n_eff = 2'(MAX_WEIGHTS);
        else
            n_eff = cfg_weights;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            w0_reg    <= weight_first;
            w1_reg    <= weight_second;
            w2_reg    <= weight_third;
            sig_reg   <= sample_value;
            last_reg  <= last_sample;
            n_reg     <= n_eff;
            mode_reg  <= cfg_mode;
            scale_reg <= cfg_scale;
            addr_reg  <= AW'(lin_addr);
            if (submap_index[12] || pixel_index[12])
                st_reg <= ST_SKIPPED;
            else if (lin_addr >= 26'(MAP_PIXELS))
                st_reg <= ST_RANGE;
            else
                st_reg <= ST_UPDATED;
        end
    end

    // Clear sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step)
            clr_reg <= clr_reg + AW'(1);
    end
    assign stat.clr_last = (32'(clr_reg) == MAP_PIXELS - 1);

    // Read stage: registered memory data
    logic [31:0]            rd_hit;
    logic signed [SumW-1:0] rd_s0, rd_s1, rd_s2;
    logic signed [SumW-1:0] rd_c0, rd_c1, rd_c2, rd_c3, rd_c4, rd_c5;

    // Products (registered before the scale multiply)
    logic signed [39:0] sw0_reg, sw1_reg, sw2_reg;
    logic signed [31:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            sw0_reg <= 40'(sig_reg) * 40'(w0_reg);
            sw1_reg <= 40'(sig_reg) * 40'(w1_reg);
            sw2_reg <= 40'(sig_reg) * 40'(w2_reg);
            p0_reg  <= 32'(w0_reg) * 32'(w0_reg);
            p1_reg  <= 32'(w0_reg) * 32'(w1_reg);
            p2_reg  <= 32'(w0_reg) * 32'(w2_reg);
            p3_reg  <= 32'(w1_reg) * 32'(w1_reg);
            p4_reg  <= 32'(w1_reg) * 32'(w2_reg);
            p5_reg  <= 32'(w2_reg) * 32'(w2_reg);
        end
    end

    // Scale multiply and rounding
    logic signed [16:0] sc;
    assign sc = {1'b0, scale_reg};

    function automatic logic signed [SumW-1:0] rnd_sig(input logic signed [39:0] p,
                                                       input logic signed [16:0] s);
        logic signed [63:0] t;
        t = 64'(p) * 64'(s) + 64'sd8192;
        return SumW'(t >>> 14);
    endfunction

    function automatic logic signed [SumW-1:0] rnd_cov(input logic signed [31:0] p,
                                                       input logic signed [16:0] s);
        logic signed [63:0] t;
        t = 64'(p) * 64'(s) + 64'sd524288;
        return SumW'(t >>> 20);
    endfunction

    logic signed [SumW-1:0] ts0_reg, ts1_reg, ts2_reg;
    logic signed [SumW-1:0] tc0_reg, tc1_reg, tc2_reg, tc3_reg, tc4_reg, tc5_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.compute)
        begin
            ts0_reg <= rnd_sig(sw0_reg, sc);
            ts1_reg <= rnd_sig(sw1_reg, sc);
            ts2_reg <= rnd_sig(sw2_reg, sc);
            tc0_reg <= rnd_cov(p0_reg, sc);
            tc1_reg <= rnd_cov(p1_reg, sc);
            tc2_reg <= rnd_cov(p2_reg, sc);
            tc3_reg <= rnd_cov(p3_reg, sc);
            tc4_reg <= rnd_cov(p4_reg, sc);
            tc5_reg <= rnd_cov(p5_reg, sc);
        end
    end

    // Update enables
    logic ok, do_hit, do_sig, do_cov, u1, u2;
    assign ok     = (st_reg == ST_UPDATED);
    assign do_hit = ok && (mode_reg != MODE_SIG);
    assign do_sig = ok && (mode_reg == MODE_ALL || mode_reg == MODE_SIG);
    assign do_cov = ok && (mode_reg == MODE_ALL || mode_reg == MODE_HIT_COV);
    assign u1     = (n_reg >= 2'd2) && (MAX_WEIGHTS >= 2);
    assign u2     = (n_reg >= 2'd3) && (MAX_WEIGHTS >= 3);

    logic [31:0]            nh;
    logic signed [SumW-1:0] ns0, ns1, ns2, nc0, nc1, nc2, nc3, nc4, nc5;
    always_comb
    begin
        nh  = (do_hit && rd_hit != 32'hFFFF_FFFF) ? rd_hit + 32'd1 : rd_hit;
        ns0 = do_sig ? sat_add(rd_s0, ts0_reg) : rd_s0;
        ns1 = (do_sig && u1) ? sat_add(rd_s1, ts1_reg) : rd_s1;
        ns2 = (do_sig && u2) ? sat_add(rd_s2, ts2_reg) : rd_s2;
        nc0 = do_cov ? sat_add(rd_c0, tc0_reg) : rd_c0;
        nc1 = (do_cov && u1) ? sat_add(rd_c1, tc1_reg) : rd_c1;
        nc2 = (do_cov && u2) ? sat_add(rd_c2, tc2_reg) : rd_c2;
        nc3 = (do_cov && u1) ? sat_add(rd_c3, tc3_reg) : rd_c3;
        nc4 = (do_cov && u2) ? sat_add(rd_c4, tc4_reg) : rd_c4;
        nc5 = (do_cov && u2) ? sat_add(rd_c5, tc5_reg) : rd_c5;
    end

    // Memory write: clear sweep or write-back; read at the item's address
    logic            we;
    logic [AW-1:0]   waddr;
    assign we    = cmd.clr_step || (cmd.write && ok);
    assign waddr = cmd.clr_step ? clr_reg : addr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hit_mem[waddr]  <= cmd.clr_step ? '0 : nh;
            sig_mem0[waddr] <= cmd.clr_step ? '0 : ns0;
            sig_mem1[waddr] <= cmd.clr_step ? '0 : ns1;
            sig_mem2[waddr] <= cmd.clr_step ? '0 : ns2;
            cov_mem0[waddr] <= cmd.clr_step ? '0 : nc0;
            cov_mem1[waddr] <= cmd.clr_step ? '0 : nc1;
            cov_mem2[waddr] <= cmd.clr_step ? '0 : nc2;
            cov_mem3[waddr] <= cmd.clr_step ? '0 : nc3;
            cov_mem4[waddr] <= cmd.clr_step ? '0 : nc4;
            cov_mem5[waddr] <= cmd.clr_step ? '0 : nc5;
        end
        if (cmd.read)
        begin
            rd_hit <= hit_mem[addr_reg];
            rd_s0  <= sig_mem0[addr_reg];
            rd_s1  <= sig_mem1[addr_reg];
            rd_s2  <= sig_mem2[addr_reg];
            rd_c0  <= cov_mem0[addr_reg];
            rd_c1  <= cov_mem1[addr_reg];
            rd_c2  <= cov_mem2[addr_reg];
            rd_c3  <= cov_mem3[addr_reg];
            rd_c4  <= cov_mem4[addr_reg];
            rd_c5  <= cov_mem5[addr_reg];
        end
    end

    // Result register; fields for weights beyond the limit read zero
    logic m1, m2;
    assign m1 = (MAX_WEIGHTS >= 2);
    assign m2 = (MAX_WEIGHTS >= 3);

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            status      <= st_reg;
            batch_done  <= last_reg;
            hit_total   <= ok ? nh : '0;
            zsum_first  <= ok ? ns0 : '0;
            zsum_second <= (ok && m1) ? ns1 : '0;
            zsum_third  <= (ok && m2) ? ns2 : '0;
            cov_aa      <= ok ? nc0 : '0;
            cov_ab      <= (ok && m1) ? nc1 : '0;
            cov_ac      <= (ok && m2) ? nc2 : '0;
            cov_bb      <= (ok && m1) ? nc3 : '0;
            cov_bc      <= (ok && m2) ? nc4 : '0;
            cov_cc      <= (ok && m2) ? nc5 : '0;
        end
    end

endmodule

// ===== rtl/pca_ctrl.sv =====
// Controller: clear sweep after reset, then capture, read, compute, write, deliver.
module pca_ctrl import pca_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  pca_stat_t stat,
    output pca_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COMP,
        S_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Accept a new item only in idle and when the result register is free or being drained
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                cmd.compute = 1'b1;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
